@@ hw/rtl/npcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_pkg
// shared constants, codes and controller/datapath interface types for the
// nearest palette color mapper
// ----------------------------------------------------------------------------
package npcm_pkg;

	localparam int PALETTE_DEPTH = 16;
	localparam int IDX_W         = $clog2(PALETTE_DEPTH);
	localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
	localparam int COLOR_W       = 24;
	localparam int SQ_W          = 16;
	localparam int DIST_W        = 18;
	localparam int USED_W        = 5;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_MAP   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		logic             clear;
		logic             start;
		logic             issue;
		logic             last;
		logic             commit;
		logic [IDX_W-1:0] rd_idx;
	} npcm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic             search_done;
		logic             out_free;
		logic [CNT_W-1:0] size_n;
	} npcm_status_t;

	// zero searches one entry, large sizes saturate at the depth
	function automatic logic [CNT_W-1:0] clamp_size(input logic [4:0] ps);
		if (ps == 5'd0)
			return CNT_W'(1);
		if (int'(ps) > PALETTE_DEPTH)
			return CNT_W'(PALETTE_DEPTH);
		return CNT_W'(ps);
	endfunction

endpackage

@@ hw/rtl/nearest_palette_color_mapper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper
// maps rgb pixels to the nearest entry of a loaded palette (squared distance)
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid / in_stall): one word carries an operation:
//   load writes pixel_red/green/blue into slot entry_index, clear drops all
//   used marks and the distinct count, map searches the palette
// - load, clear and the unused code give no result
// - a map compares one palette entry per cycle (one ram read port feeding a
//   distance pipeline); after the search the controller drains the pipeline,
//   then commits the result word to the output register and goes back to
//   idle, where the next word is taken; in_stall stays high meanwhile
// - output channel (out_valid / out_stall): one word per map with the color,
//   chosen_index (lowest on ties), first_use and distinct_used
// - the output register frees the input side: the next word is taken while
//   a result still waits; a stalled result holds and a later map waits in
//   its commit step until the register frees up
// - config channel (cfg_valid / cfg_ready): palette_size, always ready,
//   write only while the block is idle
// - reset: palette_size 16, used marks and count zero, no result pending;
//   palette entries hold garbage until loaded
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper (
	input  logic       clk,
	input  logic       arst_n,
	// config
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_palette_size,
	// input words
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [3:0] entry_index,
	input  logic [7:0] pixel_red,
	input  logic [7:0] pixel_green,
	input  logic [7:0] pixel_blue,
	// result words
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] mapped_red,
	output logic [7:0] mapped_green,
	output logic [7:0] mapped_blue,
	output logic [3:0] chosen_index,
	output logic       first_use,
	output logic [4:0] distinct_used
);
	import npcm_pkg::*;

	npcm_cmd_t    cmd;
	npcm_status_t status;

	// register is a plain flop, so writes are always taken
	assign cfg_ready = 1'b1;

	npcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.status    (status)
	);

	npcm_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_palette_size (cfg_palette_size),
		.entry_index      (entry_index),
		.pixel_red        (pixel_red),
		.pixel_green      (pixel_green),
		.pixel_blue       (pixel_blue),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.mapped_red       (mapped_red),
		.mapped_green     (mapped_green),
		.mapped_blue      (mapped_blue),
		.chosen_index     (chosen_index),
		.first_use        (first_use),
		.distinct_used    (distinct_used)
	);

	// an accepted map holds off the next word while the search runs
	a_map_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (operation == OP_MAP)) |=> in_stall)
		else $error("map accepted but input not stalled");

	// a first use always counts, so the count cannot be zero
	a_first_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && first_use) |-> (distinct_used != 5'd0))
		else $error("first use reported with zero distinct count");

	// never more distinct entries than palette slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(distinct_used) <= PALETTE_DEPTH))
		else $error("distinct count exceeds palette depth");

	// commit only happens when the output register can take the word
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || !out_stall))
		else $error("result committed over a stalled word");

endmodule

@@ hw/rtl/npcm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module npcm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/npcm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_ctrl
// sequencer: accepts words, steps the palette search, commits the result
// ----------------------------------------------------------------------------
module npcm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            operation,
	output logic                  in_stall,
	output npcm_pkg::npcm_cmd_t    cmd,
	input  npcm_pkg::npcm_status_t status
);
	import npcm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DRAIN,
		S_COMMIT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             accept;
	logic             is_last;

	assign accept  = in_valid && (state_q == S_IDLE);
	assign is_last = (CNT_W'(rd_idx_q) + CNT_W'(1)) == status.size_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rd_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (operation == OP_MAP)) begin
						state_q  <= S_SEARCH;
						rd_idx_q <= '0;
					end
				end
				S_SEARCH: begin
					if (is_last)
						state_q <= S_DRAIN;
					else
						rd_idx_q <= rd_idx_q + 1'b1;
				end
				S_DRAIN: begin
					if (status.search_done)
						state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (status.out_free)
						state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.load   = accept && (operation == OP_LOAD);
		cmd.clear  = accept && (operation == OP_CLEAR);
		cmd.start  = accept && (operation == OP_MAP);
		cmd.issue  = (state_q == S_SEARCH);
		cmd.last   = is_last;
		cmd.rd_idx = rd_idx_q;
		cmd.commit = (state_q == S_COMMIT) && status.out_free;
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

@@ hw/rtl/npcm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_datapath
// palette store, distance pipeline, best tracker, used marks, output word
// ----------------------------------------------------------------------------
module npcm_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  npcm_pkg::npcm_cmd_t     cmd,
	output npcm_pkg::npcm_status_t  status,
	input  logic                   cfg_we,
	input  logic [4:0]             cfg_palette_size,
	input  logic [3:0]             entry_index,
	input  logic [7:0]             pixel_red,
	input  logic [7:0]             pixel_green,
	input  logic [7:0]             pixel_blue,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             mapped_red,
	output logic [7:0]             mapped_green,
	output logic [7:0]             mapped_blue,
	output logic [3:0]             chosen_index,
	output logic                   first_use,
	output logic [4:0]             distinct_used
);
	import npcm_pkg::*;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

	logic [4:0]         palette_size_q;
	logic [23:0]        pixel_q;
	logic [COLOR_W-1:0] rdata;
	logic               ram_we;

	logic               v_s1, last_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               v_s2, last_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [COLOR_W-1:0] color_s2;
	logic [SQ_W-1:0]    sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0]  dist_sum;

	logic [DIST_W-1:0]  best_dist_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [COLOR_W-1:0] best_color_q;
	logic               done_q;

	logic [PALETTE_DEPTH-1:0] used_q;
	logic [USED_W-1:0]        used_count_q;
	logic                     first_now;
	logic [USED_W-1:0]        count_next;

	logic               out_valid_q;
	logic [COLOR_W-1:0] out_color_q;
	logic [3:0]         out_idx_q;
	logic               out_first_q;
	logic [USED_W-1:0]  out_count_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			palette_size_q <= 5'd16;
		else if (cfg_we)
			palette_size_q <= cfg_palette_size;
	end

	always_ff @(posedge clk) begin
		if (cmd.start)
			pixel_q <= {pixel_red, pixel_green, pixel_blue};
	end

	// loads beyond the depth are dropped
	assign ram_we = cmd.load && (int'(entry_index) < PALETTE_DEPTH);

	npcm_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(entry_index)),
		.wdata ({pixel_red, pixel_green, pixel_blue}),
		.re    (cmd.issue),
		.raddr (cmd.rd_idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			v_s2   <= v_s1;
			done_q <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s1  <= cmd.last;
		idx_s1   <= cmd.rd_idx;
		last_s2  <= last_s1;
		idx_s2   <= idx_s1;
		color_s2 <= rdata;
		sq_r_s2  <= sq_diff(pixel_q[23:16], rdata[23:16]);
		sq_g_s2  <= sq_diff(pixel_q[15:8], rdata[15:8]);
		sq_b_s2  <= sq_diff(pixel_q[7:0], rdata[7:0]);
	end

	assign dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

	// strict less-than keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (v_s2 && ((idx_s2 == '0) || (dist_sum < best_dist_q))) begin
			best_dist_q  <= dist_sum;
			best_idx_q   <= idx_s2;
			best_color_q <= color_s2;
		end
	end

	assign first_now  = !used_q[best_idx_q];
	assign count_next = (first_now && (used_count_q != '1)) ? used_count_q + 1'b1
	                                                         : used_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			used_count_q <= '0;
		end else if (cmd.clear) begin
			used_q       <= '0;
			used_count_q <= '0;
		end else if (cmd.commit) begin
			used_q[best_idx_q] <= 1'b1;
			used_count_q       <= count_next;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.commit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_color_q <= best_color_q;
			out_idx_q   <= 4'(best_idx_q);
			out_first_q <= first_now;
			out_count_q <= count_next;
		end
	end

	assign status.search_done = done_q;
	assign status.out_free    = !out_valid_q || !out_stall;
	assign status.size_n      = clamp_size(palette_size_q);

	assign out_valid     = out_valid_q;
	assign mapped_red    = out_color_q[23:16];
	assign mapped_green  = out_color_q[15:8];
	assign mapped_blue   = out_color_q[7:0];
	assign chosen_index  = out_idx_q;
	assign first_use     = out_first_q;
	assign distinct_used = out_count_q;

endmodule
